>>> hw/rtl/v3alu_pkg.sv
package v3alu_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegW     = 31;
  localparam int unsigned NumRegs  = 2;

  // Division is signed 49-bit by 32-bit, one quotient bit per cell.
  localparam int unsigned DivNumW  = DataW + FracBits + 1;
  localparam int unsigned DivCells = DivNumW;
  // Square root of a 66-bit sum of squares, one result bit per cell.
  localparam int unsigned SqW      = 66;
  localparam int unsigned SqrtCells = SqW / 2;
  localparam int unsigned SqrtRootW = SqrtCells + 1;

  localparam int unsigned CmdW = 4;

  typedef enum logic [CmdW-1:0] {
    CmdAdd    = 4'd0,
    CmdSub    = 4'd1,
    CmdNeg    = 4'd2,
    CmdScale  = 4'd3,
    CmdDiv    = 4'd4,
    CmdDot    = 4'd5,
    CmdCross  = 4'd6,
    CmdLenSq  = 4'd7,
    CmdMag    = 4'd8,
    CmdNorm   = 4'd9,
    CmdEq     = 4'd10,
    CmdNeq    = 4'd11
  } cmd_e;

  typedef enum logic {
    RegEqTol   = 1'b0,
    RegZeroThr = 1'b1
  } reg_e;

  typedef logic signed [DataW-1:0] word_t;

  // One result transaction as it leaves the front stages.
  typedef struct packed {
    word_t rx;
    word_t ry;
    word_t rz;
    word_t sc;
    logic  cmp;
    logic  err;
  } res_t;

  // Per-lane divider job carried through the cell chain.
  typedef struct packed {
    logic                      neg;
    logic [DivNumW-1:0]        rem;
    logic [DivNumW-1:0]        num;
    logic [DivNumW-1:0]        quo;
    logic [DataW-1:0]          den;
    logic                      dz;
    logic                      zero_num;
    logic                      num_pos;
  } div_lane_t;

  function automatic word_t sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return word_t'(32'h7fffffff);
    end else if (v < -68'sd2147483648) begin
      return word_t'(32'h80000000);
    end else begin
      return v[DataW-1:0];
    end
  endfunction

  function automatic logic ovf32(input logic signed [67:0] v);
    return (v > 68'sd2147483647) || (v < -68'sd2147483648);
  endfunction

  // Round to nearest (ties up) and drop the fraction.
  function automatic logic signed [67:0] rnd(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = v + (68'sd1 <<< (FracBits - 1));
    return t >>> FracBits;
  endfunction

endpackage

>>> hw/rtl/v3alu_div_cell.sv
module v3alu_div_cell (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  v3alu_pkg::div_lane_t [2:0]                  lane_i,
  input  v3alu_pkg::res_t                             res_i,
  input  logic [v3alu_pkg::CmdW-1:0]                  cmd_i,
  output v3alu_pkg::div_lane_t [2:0]                  lane_o,
  output v3alu_pkg::res_t                             res_o,
  output logic [v3alu_pkg::CmdW-1:0]                  cmd_o
);

  v3alu_pkg::div_lane_t [2:0] lane_d, lane_q;
  logic [v3alu_pkg::DivNumW:0] trial [3];

  // Restoring step: shift in the next numerator bit, subtract if it fits.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lane_d[l] = lane_i[l];
      trial[l]  = {lane_i[l].rem, lane_i[l].num[v3alu_pkg::DivNumW-1]}
                  - {{(v3alu_pkg::DivNumW-v3alu_pkg::DataW+1){1'b0}}, lane_i[l].den};
      lane_d[l].num = {lane_i[l].num[v3alu_pkg::DivNumW-2:0], 1'b0};
      if (!trial[l][v3alu_pkg::DivNumW]) begin
        lane_d[l].rem = trial[l][v3alu_pkg::DivNumW-1:0];
        lane_d[l].quo = {lane_i[l].quo[v3alu_pkg::DivNumW-2:0], 1'b1};
      end else begin
        lane_d[l].rem = {lane_i[l].rem[v3alu_pkg::DivNumW-2:0],
                         lane_i[l].num[v3alu_pkg::DivNumW-1]};
        lane_d[l].quo = {lane_i[l].quo[v3alu_pkg::DivNumW-2:0], 1'b0};
      end
    end
  end

  v3alu_pkg::res_t           res_q;
  logic [v3alu_pkg::CmdW-1:0] cmd_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      res_q  <= res_i;
      cmd_q  <= cmd_i;
    end
  end

  assign lane_o = lane_q;
  assign res_o  = res_q;
  assign cmd_o  = cmd_q;

endmodule

>>> hw/rtl/v3alu_sqrt_cell.sv
module v3alu_sqrt_cell (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [v3alu_pkg::SqW-1:0]              rem_i,
  input  logic [v3alu_pkg::SqW-1:0]              rad_i,
  input  logic [v3alu_pkg::SqrtRootW-1:0]        root_i,
  output logic [v3alu_pkg::SqW-1:0]              rem_o,
  output logic [v3alu_pkg::SqW-1:0]              rad_o,
  output logic [v3alu_pkg::SqrtRootW-1:0]        root_o
);

  logic [v3alu_pkg::SqW-1:0]       rem_d, rad_d, rem_q, rad_q, cur;
  logic [v3alu_pkg::SqW-1:0]       tst;
  logic [v3alu_pkg::SqrtRootW-1:0] root_d, root_q;

  // Bring down two radicand bits, try 4r+1.
  always_comb begin
    cur   = {rem_i[v3alu_pkg::SqW-3:0], rad_i[v3alu_pkg::SqW-1 -: 2]};
    tst   = {{(v3alu_pkg::SqW-v3alu_pkg::SqrtRootW-2){1'b0}}, root_i, 2'b01};
    rad_d = {rad_i[v3alu_pkg::SqW-3:0], 2'b00};
    if (cur >= tst) begin
      rem_d  = cur - tst;
      root_d = {root_i[v3alu_pkg::SqrtRootW-2:0], 1'b1};
    end else begin
      rem_d  = cur;
      root_d = {root_i[v3alu_pkg::SqrtRootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      rad_q  <= rad_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign rad_o  = rad_q;
  assign root_o = root_q;

endmodule

>>> hw/rtl/vector3_fixed_point_alu_top.sv
// The datapath has 4 + 33 + 2 + 49 + 1 = 89 register stages, from the input
// capture register to the output register.
// Throughput: one transaction per cycle; every stage is a cell of a chain,
// and the whole chain advances whenever the output register is empty or drained.
// Reset (rst_ni low, asynchronous): clears all valid bits, sets
// equal_tolerance to 1 and zero_length_threshold to 0.
module vector3_fixed_point_alu_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [v3alu_pkg::RegW-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [3:0]                         command_i,
  input  logic signed [31:0]                 ax_i,
  input  logic signed [31:0]                 ay_i,
  input  logic signed [31:0]                 az_i,
  input  logic signed [31:0]                 bx_i,
  input  logic signed [31:0]                 by_i,
  input  logic signed [31:0]                 bz_i,
  input  logic signed [31:0]                 scalar_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [31:0]                 rx_o,
  output logic signed [31:0]                 ry_o,
  output logic signed [31:0]                 rz_o,
  output logic signed [31:0]                 scalar_out_o,
  output logic                               compare_flag_o,
  output logic                               error_flag_o
);

  localparam int unsigned NS = 4 + v3alu_pkg::SqrtCells + 2 + v3alu_pkg::DivCells;

  logic [v3alu_pkg::RegW-1:0] eq_tol_q, zero_thr_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_tol_q   <= v3alu_pkg::RegW'(1);
      zero_thr_q <= '0;
    end else if (cfg_we_i) begin
      case (v3alu_pkg::reg_e'(cfg_idx_i))
        v3alu_pkg::RegEqTol:   eq_tol_q   <= cfg_wdata_i;
        v3alu_pkg::RegZeroThr: zero_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Global advance: the chain moves whenever the output slot is empty or is
  // being drained. A bubble just moves along with its valid bit low.
  logic adv;
  logic [NS-1:0] vld_q;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: capture the transaction; simple sums and differences come in stage 4.
  // ---------------------------------------------------------------------
  typedef logic signed [v3alu_pkg::DataW-1:0] w_t;
  logic [3:0] cmd1_q;
  w_t a1_q [3];
  w_t b1_q [3];
  w_t s1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q <= command_i;
      a1_q[0] <= ax_i; a1_q[1] <= ay_i; a1_q[2] <= az_i;
      b1_q[0] <= bx_i; b1_q[1] <= by_i; b1_q[2] <= bz_i;
      s1_q <= scalar_in_i;
    end
  end

  // Stage 2: fifteen 32x32 products, each to its own register.
  // p[0..2] a_i*b_i, p[3..5] a_i*a_i, p[6..8] a_i*s, c[0..5] cross terms.
  logic signed [63:0] p2_q [9];
  logic signed [63:0] c2_q [6];
  logic [3:0] cmd2_q;
  w_t a2_q [3];
  w_t b2_q [3];
  w_t s2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p2_q[i]   <= a1_q[i] * b1_q[i];
        p2_q[3+i] <= a1_q[i] * a1_q[i];
        p2_q[6+i] <= a1_q[i] * s1_q;
      end
      c2_q[0] <= a1_q[1] * b1_q[2];
      c2_q[1] <= a1_q[2] * b1_q[1];
      c2_q[2] <= a1_q[2] * b1_q[0];
      c2_q[3] <= a1_q[0] * b1_q[2];
      c2_q[4] <= a1_q[0] * b1_q[1];
      c2_q[5] <= a1_q[1] * b1_q[0];
      cmd2_q <= cmd1_q;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      s2_q   <= s1_q;
    end
  end

  // Stage 3: sums of products.
  logic signed [67:0] dot3_q, lsq3_q, cr3_q [3];
  logic [v3alu_pkg::SqW-1:0] sq3_q;
  logic signed [63:0] sc3_q [3];
  logic [3:0] cmd3_q;
  w_t a3_q [3];
  w_t b3_q [3];
  w_t s3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dot3_q <= 68'(p2_q[0]) + 68'(p2_q[1]) + 68'(p2_q[2]);
      lsq3_q <= 68'(p2_q[3]) + 68'(p2_q[4]) + 68'(p2_q[5]);
      sq3_q  <= v3alu_pkg::SqW'(p2_q[3]) + v3alu_pkg::SqW'(p2_q[4])
                + v3alu_pkg::SqW'(p2_q[5]);
      for (int i = 0; i < 3; i++) sc3_q[i] <= p2_q[6+i];
      cr3_q[0] <= 68'(c2_q[0]) - 68'(c2_q[1]);
      cr3_q[1] <= 68'(c2_q[2]) - 68'(c2_q[3]);
      cr3_q[2] <= 68'(c2_q[4]) - 68'(c2_q[5]);
      cmd3_q <= cmd2_q;
      a3_q   <= a2_q;
      b3_q   <= b2_q;
      s3_q   <= s2_q;
    end
  end

  // Stage 4: every command except magnitude, normalize and divide finishes.
  v3alu_pkg::res_t res4_d, res4_q;
  logic signed [67:0] r4 [3];
  logic signed [32:0] d4 [3];
  logic [32:0] ad4 [3];
  logic eq4, lsq_big4_d, lsq_big4_q;
  w_t a4_q [3];
  w_t s4_q;
  logic [3:0] cmd4_q;
  logic [v3alu_pkg::SqW-1:0] sq4_q;

  always_comb begin
    res4_d = '0;
    eq4    = 1'b1;
    for (int i = 0; i < 3; i++) begin
      d4[i]  = 33'(a3_q[i]) - 33'(b3_q[i]);
      ad4[i] = d4[i][32] ? 33'(-d4[i]) : d4[i];
      if (ad4[i] >= {2'b00, eq_tol_q}) eq4 = 1'b0;
      r4[i] = '0;
    end
    lsq_big4_d = v3alu_pkg::rnd(lsq3_q) > 68'($unsigned(zero_thr_q));
    case (cmd3_q)
      v3alu_pkg::CmdAdd, v3alu_pkg::CmdSub, v3alu_pkg::CmdNeg: begin
        for (int i = 0; i < 3; i++) begin
          if (cmd3_q == v3alu_pkg::CmdAdd)      r4[i] = 68'(a3_q[i]) + 68'(b3_q[i]);
          else if (cmd3_q == v3alu_pkg::CmdSub) r4[i] = 68'(a3_q[i]) - 68'(b3_q[i]);
          else                                  r4[i] = -68'(a3_q[i]);
        end
      end
      v3alu_pkg::CmdScale: begin
        for (int i = 0; i < 3; i++) r4[i] = v3alu_pkg::rnd(68'(sc3_q[i]));
      end
      v3alu_pkg::CmdCross: begin
        for (int i = 0; i < 3; i++) r4[i] = v3alu_pkg::rnd(cr3_q[i]);
      end
      v3alu_pkg::CmdDot, v3alu_pkg::CmdLenSq: begin
        r4[0] = v3alu_pkg::rnd(cmd3_q == v3alu_pkg::CmdDot ? dot3_q : lsq3_q);
        res4_d.sc  = v3alu_pkg::sat32(r4[0]);
        res4_d.err = v3alu_pkg::ovf32(r4[0]);
        r4[0] = '0;
      end
      v3alu_pkg::CmdEq:  res4_d.cmp = eq4;
      v3alu_pkg::CmdNeq: res4_d.cmp = !eq4;
      default: ;
    endcase
    res4_d.rx = v3alu_pkg::sat32(r4[0]);
    res4_d.ry = v3alu_pkg::sat32(r4[1]);
    res4_d.rz = v3alu_pkg::sat32(r4[2]);
    for (int i = 0; i < 3; i++) if (v3alu_pkg::ovf32(r4[i])) res4_d.err = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res4_q     <= res4_d;
      lsq_big4_q <= lsq_big4_d;
      a4_q       <= a3_q;
      s4_q       <= s3_q;
      cmd4_q     <= cmd3_q;
      sq4_q      <= sq3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Square root chain: one root bit per cell. Side data (the early result, command,
  // the length threshold flag, a vector and scalar) rides along in delay registers.
  // ---------------------------------------------------------------------
  localparam int unsigned SideW = $bits(v3alu_pkg::res_t) + 4 + 1 + 4 * 32;
  localparam int unsigned SC = v3alu_pkg::SqrtCells;

  logic [v3alu_pkg::SqW-1:0]       sq_rem [SC+1];
  logic [v3alu_pkg::SqW-1:0]       sq_rad [SC+1];
  logic [v3alu_pkg::SqrtRootW-1:0] sq_root [SC+1];
  logic [SideW-1:0]                side [SC+1];

  assign sq_rem[0]  = '0;
  assign sq_rad[0]  = sq4_q;
  assign sq_root[0] = '0;
  assign side[0]    = {res4_q, cmd4_q, lsq_big4_q, a4_q[0], a4_q[1], a4_q[2], s4_q};

  for (genvar g = 0; g < SC; g++) begin : g_sqrt
    logic [SideW-1:0] side_q;
    v3alu_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (sq_rem[g]),
      .rad_i  (sq_rad[g]),
      .root_i (sq_root[g]),
      .rem_o  (sq_rem[g+1]),
      .rad_o  (sq_rad[g+1]),
      .root_o (sq_root[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) side_q <= side[g];
    end
    assign side[g+1] = side_q;
  end

  // Stage after the root: round the root.
  v3alu_pkg::res_t sres;
  logic [3:0] scmd;
  logic sbig;
  w_t sa [3];
  w_t ss;
  assign {sres, scmd, sbig, sa[0], sa[1], sa[2], ss} = side[SC];

  logic [v3alu_pkg::SqrtRootW-1:0] m_d, m_q;
  assign m_d = sq_root[SC] + v3alu_pkg::SqrtRootW'(sq_rem[SC] > v3alu_pkg::SqW'(sq_root[SC]));

  v3alu_pkg::res_t rm_q;
  logic [3:0] cmdm_q;
  logic bigm_q;
  w_t am_q [3];
  w_t sm_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q    <= m_d;
      rm_q   <= sres;
      cmdm_q <= scmd;
      bigm_q <= sbig;
      am_q   <= sa;
      sm_q   <= ss;
    end
  end

  // Resolve magnitude and build divider lanes: |a| << F divided by |s| or by m.
  v3alu_pkg::res_t rd_d, rd_q;
  v3alu_pkg::div_lane_t [2:0] ln_d, ln_q;
  logic [3:0] cmdd_q;
  logic nz_d, nz_q;
  logic [32:0] aa [3];
  logic [32:0] den_abs;
  logic den_neg;

  always_comb begin
    rd_d = rm_q;
    nz_d = bigm_q && (m_q != '0);
    den_neg = 1'b0;
    den_abs = '0;
    if (cmdm_q == v3alu_pkg::CmdMag) begin
      if (m_q > v3alu_pkg::SqrtRootW'(32'h7fffffff)) begin
        rd_d.sc  = 32'sh7fffffff;
        rd_d.err = 1'b1;
      end else begin
        rd_d.sc = m_q[31:0];
      end
    end else if (cmdm_q == v3alu_pkg::CmdDiv) begin
      den_neg = sm_q[31];
      den_abs = sm_q[31] ? 33'(-33'(sm_q)) : 33'(sm_q);
    end else begin
      den_abs = 33'(m_q);
    end
    for (int i = 0; i < 3; i++) begin
      aa[i] = am_q[i][31] ? 33'(-33'(am_q[i])) : 33'(am_q[i]);
      ln_d[i].neg      = am_q[i][31] ^ den_neg;
      ln_d[i].rem      = '0;
      ln_d[i].num      = v3alu_pkg::DivNumW'({aa[i], {v3alu_pkg::FracBits{1'b0}}});
      ln_d[i].quo      = '0;
      ln_d[i].den      = den_abs[31:0];
      ln_d[i].dz       = (den_abs == '0);
      ln_d[i].zero_num = (am_q[i] == '0);
      ln_d[i].num_pos  = !am_q[i][31];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q   <= rd_d;
      ln_q   <= ln_d;
      cmdd_q <= cmdm_q;
      nz_q   <= nz_d;
    end
  end

  // Divider chain: one quotient bit per cell, three lanes in parallel.
  localparam int unsigned DC = v3alu_pkg::DivCells;
  v3alu_pkg::div_lane_t [2:0] dl [DC+1];
  v3alu_pkg::res_t            dr [DC+1];
  logic [v3alu_pkg::CmdW-1:0] dc [DC+1];
  logic                       dnz [DC+1];

  assign dl[0]  = ln_q;
  assign dr[0]  = rd_q;
  assign dc[0]  = cmdd_q;
  assign dnz[0] = nz_q;

  for (genvar g = 0; g < DC; g++) begin : g_div
    logic nz_q2;
    v3alu_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .lane_i (dl[g]),
      .res_i  (dr[g]),
      .cmd_i  (dc[g]),
      .lane_o (dl[g+1]),
      .res_o  (dr[g+1]),
      .cmd_o  (dc[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) nz_q2 <= dnz[g];
    end
    assign dnz[g+1] = nz_q2;
  end

  // Final stage: sign, saturate, pick the result, into the output register.
  v3alu_pkg::res_t fin_d, out_q;
  logic signed [67:0] qs [3];
  w_t qv [3];

  always_comb begin
    fin_d = dr[DC];
    for (int i = 0; i < 3; i++) begin
      qs[i] = dl[DC][i].neg ? -68'(dl[DC][i].quo) : 68'(dl[DC][i].quo);
      qv[i] = v3alu_pkg::sat32(qs[i]);
    end
    if (dc[DC] == v3alu_pkg::CmdDiv) begin
      for (int i = 0; i < 3; i++) begin
        if (dl[DC][i].dz) begin
          qv[i] = dl[DC][i].zero_num ? 32'sd0 :
                  (dl[DC][i].num_pos ? 32'sh7fffffff : 32'sh80000000);
          fin_d.err = 1'b1;
        end else if (v3alu_pkg::ovf32(qs[i])) begin
          fin_d.err = 1'b1;
        end
      end
      fin_d.rx = qv[0]; fin_d.ry = qv[1]; fin_d.rz = qv[2];
    end else if (dc[DC] == v3alu_pkg::CmdNorm) begin
      if (dnz[DC]) begin
        fin_d.rx = qv[0]; fin_d.ry = qv[1]; fin_d.rz = qv[2];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= fin_d;
  end

  assign rx_o           = out_q.rx;
  assign ry_o           = out_q.ry;
  assign rz_o           = out_q.rz;
  assign scalar_out_o   = out_q.sc;
  assign compare_flag_o = out_q.cmp;
  assign error_flag_o   = out_q.err;

endmodule
